>>> design/assert_macros.svh
// Assertion helpers used by binding_stack_lookup.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with reset disable.
`define ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never hold.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   `ASSERT_PROP(label, clk, rst, !(cond), msg)

`endif

>>> design/bsl_pkg.sv
package bsl_pkg;

   localparam int DEPTH_DEF = 64;
   localparam int VAR_W     = 31;
   localparam int TERM_W    = 31;
   localparam int TAKE_W    = 7;

   typedef enum logic [1:0] {
      FUNC_PUSH    = 2'd0,
      FUNC_LOOKUP  = 2'd1,
      FUNC_COLLECT = 2'd2,
      FUNC_CLEAR   = 2'd3
   } func_type;

   typedef struct packed {
      func_type            func;
      logic [VAR_W-1:0]    var_index;
      logic [TERM_W-1:0]   bound_term;
      logic [TAKE_W-1:0]   take_count;
   } req_type;

   typedef struct packed {
      logic [TERM_W-1:0]   result_term;
      logic                found;
      logic                last;
      logic                error;
   } rsp_type;

   typedef struct packed {
      logic [VAR_W-1:0]    var_id;
      logic [TERM_W-1:0]   term;
   } entry_type;

   // shift: every cell takes its lower neighbor; load: head takes the new entry
   // instead of the tail (push versus rotate)
   typedef struct packed {
      logic shift;
      logic load;
   } chain_ctl_type;

endpackage

>>> design/bsl_cell.sv
module bsl_cell (
   input  logic               clock,
   input  logic               shift_en,
   input  bsl_pkg::entry_type prev_entry,
   output bsl_pkg::entry_type entry
);
   import bsl_pkg::*;

   entry_type entry_ff;

   // Take the neighbor's binding on each shift, hold otherwise.
   always_ff @(posedge clock) begin
      if (shift_en) begin
         entry_ff <= prev_entry;
      end
   end

   assign entry = entry_ff;

endmodule

>>> design/bsl_chain.sv
module bsl_chain #(
   parameter int DEPTH = bsl_pkg::DEPTH_DEF
) (
   input  logic                   clock,
   input  bsl_pkg::chain_ctl_type ctl,
   input  bsl_pkg::entry_type     new_entry,
   output bsl_pkg::entry_type     tap
);
   import bsl_pkg::*;

   entry_type links [DEPTH];
   entry_type head_in;

   // Push feeds the head from outside; a rotate closes the ring.
   assign head_in = ctl.load ? new_entry : links[DEPTH-1];
   assign tap     = links[DEPTH-1];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_head
         bsl_cell u_cell (
            .clock      (clock),
            .shift_en   (ctl.shift),
            .prev_entry (head_in),
            .entry      (links[i])
         );
      end else begin : g_body
         bsl_cell u_cell (
            .clock      (clock),
            .shift_en   (ctl.shift),
            .prev_entry (links[i-1]),
            .entry      (links[i])
         );
      end
   end

endmodule

>>> design/binding_stack_lookup.sv
// Binding stack with lookup and collect.
// Requests enter on req_valid/req_ready carrying func, var_index, bound_term and
// take_count; responses leave on rsp_valid/rsp_ready from a response register.
// Bindings live in a chain of DEPTH cells, newest in the head cell. A push
// shifts the chain by one and answers in the cycle after acceptance. A lookup
// or a collect rotates the whole ring once, one cell per cycle past the tail
// tap unless the receiver stalls it; the ring ends where it started. Lookup
// answers once at the end of the pass; collect emits its take_count terms,
// oldest first, as the last take_count cells reach the tap. A clear or a
// zero-term collect starts no pass and sends no response. Push to a full
// stack and collect beyond the fill count answer at once with the error flag.
// One request is in work at a time; req_ready is high when no pass runs and the
// response register is free or being drained.
// When rsp_ready is low a waiting response holds, and a pass pauses at the
// next result it has to place.
// Reset (synchronous, active high) empties the stack by zeroing the fill
// count; the cells need no clearing pass.
`include "assert_macros.svh"

module binding_stack_lookup #(
   parameter int DEPTH = bsl_pkg::DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bsl_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bsl_pkg::rsp_type rsp_data
);
   import bsl_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   typedef enum logic {ST_IDLE, ST_SCAN} state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               collect_ff, collect_in;
   logic [VAR_W-1:0]   key_ff, key_in;
   logic [TAKE_W-1:0]  take_ff, take_in;
   logic               hit_ff, hit_in;
   logic [TERM_W-1:0]  hit_term_ff, hit_term_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   chain_ctl_type      ctl;
   entry_type          new_entry;
   entry_type          tap;

   logic out_free;
   logic accept;
   logic full;
   logic tap_match;
   logic in_take;
   logic emit_now;
   logic advance;

   assign new_entry.var_id = req_data.var_index;
   assign new_entry.term   = req_data.bound_term;

   bsl_chain #(.DEPTH(DEPTH)) u_chain (
      .clock     (clock),
      .ctl       (ctl),
      .new_entry (new_entry),
      .tap       (tap)
   );

   // The response register is free when empty or drained this cycle.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign full      = (fill_ff == CNT_W'(DEPTH));

   // The tail tap holds binding idx_ff (0 is newest) during a pass.
   assign tap_match = (CNT_W'(idx_ff) < fill_ff) && (tap.var_id == key_ff);
   assign in_take   = TAKE_W'(idx_ff) < take_ff;
   assign emit_now  = collect_ff ? in_take : (idx_ff == '0);
   // Pause the ring only when a response is due and the register is taken.
   assign advance   = (state_ff == ST_SCAN) && (out_free || !emit_now);

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      idx_in       = idx_ff;
      collect_in   = collect_ff;
      key_in       = key_ff;
      take_in      = take_ff;
      hit_in       = hit_ff;
      hit_term_in  = hit_term_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      ctl          = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_data.func)
                  FUNC_PUSH: begin
                     rsp_valid_in       = 1'b1;
                     rsp_in.result_term = '0;
                     rsp_in.found       = 1'b0;
                     rsp_in.last        = 1'b1;
                     rsp_in.error       = full;
                     if (!full) begin
                        ctl.shift = 1'b1;
                        ctl.load  = 1'b1;
                        fill_in   = fill_ff + 1'b1;
                     end
                  end
                  FUNC_LOOKUP: begin
                     state_in    = ST_SCAN;
                     collect_in  = 1'b0;
                     key_in      = req_data.var_index;
                     hit_in      = 1'b0;
                     hit_term_in = '0;
                     idx_in      = IDX_W'(DEPTH - 1);
                  end
                  FUNC_COLLECT: begin
                     if (req_data.take_count > TAKE_W'(fill_ff)) begin
                        rsp_valid_in       = 1'b1;
                        rsp_in.result_term = '0;
                        rsp_in.found       = 1'b0;
                        rsp_in.last        = 1'b1;
                        rsp_in.error       = 1'b1;
                     end else if (req_data.take_count != '0) begin
                        state_in   = ST_SCAN;
                        collect_in = 1'b1;
                        take_in    = req_data.take_count;
                        idx_in     = IDX_W'(DEPTH - 1);
                     end
                  end
                  FUNC_CLEAR: begin
                     fill_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (advance) begin
               // Rotate one cell; newer matches override older ones.
               ctl.shift = 1'b1;
               idx_in    = idx_ff - 1'b1;
               if (tap_match) begin
                  hit_in      = 1'b1;
                  hit_term_in = tap.term;
               end
               if (emit_now) begin
                  rsp_valid_in = 1'b1;
                  rsp_in.error = 1'b0;
                  if (collect_ff) begin
                     rsp_in.result_term = tap.term;
                     rsp_in.found       = 1'b0;
                     rsp_in.last        = (idx_ff == '0);
                  end else begin
                     rsp_in.result_term = tap_match ? tap.term : hit_term_ff;
                     rsp_in.found       = tap_match || hit_ff;
                     rsp_in.last        = 1'b1;
                  end
               end
               if (idx_ff == '0) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      collect_ff  <= collect_in;
      key_ff      <= key_in;
      take_ff     <= take_in;
      hit_ff      <= hit_in;
      hit_term_ff <= hit_term_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Fill count stays within the chain.
   `ASSERT_NEVER(a_fill_range, clock, reset, fill_ff > CNT_W'(DEPTH), "fill count overflow")
   // A pass leaves the fill count alone.
   `ASSERT_PROP(a_scan_fill, clock, reset,
      (state_ff == ST_SCAN) |=> $stable(fill_ff), "fill changed in pass")
   // Errors never come with a hit.
   `ASSERT_NEVER(a_err_found, clock, reset,
      rsp_valid && rsp_data.found && rsp_data.error, "error with found")
   // A stalled pass does not move the ring.
   `ASSERT_NEVER(a_stall_hold, clock, reset,
      (state_ff == ST_SCAN) && emit_now && !out_free && ctl.shift, "ring moved in stall")

endmodule
